FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock, off while reset is low
`define HCBD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hcbd assertion failed");

// antecedent implies consequent in the same cycle
`define HCBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbd implication failed");

`endif

FILE: rtl/hcbd_pkg.sv
// types and constants of the chunked body decoder
package hcbd_pkg;

  // result kinds
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW = 3'd1;
  localparam logic [2:0] ERR_EMPTY    = 3'd2;
  localparam logic [2:0] ERR_SIZE_LF  = 3'd3;
  localparam logic [2:0] ERR_DATA_CRLF = 3'd4;
  localparam logic [2:0] ERR_LAST_CRLF = 3'd5;

  // characters of interest
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // depth of the queue between classifier and parser
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified input beat
  typedef struct packed {
    logic       restart;
    logic       is_zero;
    logic       is_semi;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] raw;
  } hcbd_cls_t;

endpackage

FILE: rtl/hcbd_if.sv
// handshake channels of the chunked body decoder
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       restart;

  modport source (output valid, in_byte, restart, input ready);
  modport sink (input valid, in_byte, restart, output ready);
endinterface

interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        chunk_end;
  logic [2:0]  error_code;
  logic [31:0] total_bytes;

  modport source (output valid, kind, data_byte, chunk_end, error_code, total_bytes,
                  input ready);
  modport sink (input valid, kind, data_byte, chunk_end, error_code, total_bytes,
                output ready);
endinterface

FILE: rtl/http_chunked_body_decoder.sv
// Chunked body decoder: one body byte in, one result beat out. A beat is taken every
// cycle while the queue is not full; each result passes through a two-entry queue and
// then the output register. The rate is set by the framing state machine in the back
// end, which finishes one byte per cycle while the sink is ready, with one wide
// decrement and compare on the chunk size and one increment of the byte total. Input
// ready drops only when the queue holds two beats, so a stalled sink holds up the
// source after at most two more bytes. Size and byte total widths follow SIZE_BITS
// and COUNT_BITS; total_bytes shows the low 32 bits of the saturating total.
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS  = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);

  // front to queue
  logic      push;
  hcbd_cls_t push_cls;
  logic      q_full;

  // queue to back
  logic      head_valid;
  hcbd_cls_t head_cls;
  logic      pop;

  // classify each incoming beat: hex digit value and framing characters
  hcbd_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cls_o    (push_cls)
  );

  // decouples acceptance from a stalled output
  hcbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cls),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cls)
  );

  // framing state machine, counters and the result register
  hcbd_back #(
    .SIZE_BITS  (SIZE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cls),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

FILE: rtl/hcbd_front.sv
// front end: takes input beats and classifies each byte
module hcbd_front import hcbd_pkg::*; (
  hcbd_in_if.sink   in_i,
  input  logic      q_full_i,
  output logic      push_o,
  output hcbd_cls_t cls_o
);

  logic       hex_dec;
  logic       hex_alo;
  logic       hex_aup;
  logic [7:0] hex_off;

  always_comb begin
    hex_dec = (in_i.in_byte >= 8'h30) && (in_i.in_byte <= 8'h39);
    hex_aup = (in_i.in_byte >= 8'h41) && (in_i.in_byte <= 8'h46);
    hex_alo = (in_i.in_byte >= 8'h61) && (in_i.in_byte <= 8'h66);
    priority if (hex_dec) begin
      hex_off = in_i.in_byte - 8'h30;
    end else if (hex_aup) begin
      hex_off = in_i.in_byte - 8'h37;
    end else begin
      hex_off = in_i.in_byte - 8'h57;
    end
  end

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  assign cls_o.restart = in_i.restart;
  assign cls_o.is_zero = in_i.in_byte == CH_ZERO;
  assign cls_o.is_semi = in_i.in_byte == CH_SEMI;
  assign cls_o.is_cr   = in_i.in_byte == CH_CR;
  assign cls_o.is_lf   = in_i.in_byte == CH_LF;
  assign cls_o.is_hex  = hex_dec || hex_aup || hex_alo;
  assign cls_o.hex_val = hex_off[3:0];
  assign cls_o.raw     = in_i.in_byte;

endmodule

FILE: rtl/hcbd_queue.sv
// short queue of classified beats between front and back
module hcbd_queue import hcbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hcbd_cls_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      head_valid_o,
  output hcbd_cls_t head_o
);

  hcbd_cls_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o       = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/hcbd_back.sv
// back end: chunk framing state machine and registered result
module hcbd_back import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS  = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  hcbd_cls_t  head_i,
  output logic       pop_o,
  hcbd_out_if.source out_o
);

  localparam logic [3:0] PH_SIZE_FIRST   = 4'd0;
  localparam logic [3:0] PH_SIZE         = 4'd1;
  localparam logic [3:0] PH_SIZE_NODIGIT = 4'd2;
  localparam logic [3:0] PH_EXT          = 4'd3;
  localparam logic [3:0] PH_SIZE_LF      = 4'd4;
  localparam logic [3:0] PH_DATA         = 4'd5;
  localparam logic [3:0] PH_DATA_CR      = 4'd6;
  localparam logic [3:0] PH_DATA_LF      = 4'd7;
  localparam logic [3:0] PH_LAST_CR      = 4'd8;
  localparam logic [3:0] PH_LAST_LF      = 4'd9;
  localparam logic [3:0] PH_DONE         = 4'd10;
  localparam logic [3:0] PH_ERROR        = 4'd11;

  localparam int unsigned TOT_W = (COUNT_BITS < 32) ? COUNT_BITS : 32;

  logic [3:0]            phase_q, phase_d;
  logic [SIZE_BITS-1:0]  rem_q, rem_d, rem_dec;
  logic                  ended_q, ended_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [2:0]            err_q, err_d;

  logic [1:0] kind;
  logic [7:0] data;
  logic       cend;
  logic       out_valid_q;

  assign pop_o = head_valid_i && (!out_valid_q || out_o.ready);
  assign rem_dec = rem_q - SIZE_BITS'(rem_q != '0);

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    ended_d = ended_q;
    total_d = total_q;
    err_d   = err_q;
    kind    = KIND_FRAME;
    data    = 8'h00;
    cend    = 1'b0;
    if (head_i.restart) begin
      phase_d = PH_SIZE_FIRST;
      rem_d   = '0;
      ended_d = 1'b0;
      total_d = '0;
      err_d   = ERR_NONE;
    end else begin
      unique case (phase_q)
        PH_SIZE_FIRST: begin
          rem_d   = '0;
          ended_d = 1'b0;
          priority if (head_i.is_zero) begin
            phase_d = PH_LAST_CR;
          end else if (head_i.is_semi || head_i.is_cr) begin
            err_d = ERR_EMPTY; phase_d = PH_ERROR; kind = KIND_ERROR;
          end else if (!head_i.is_hex) begin
            phase_d = PH_SIZE_NODIGIT;
          end else begin
            rem_d   = SIZE_BITS'(head_i.hex_val);
            phase_d = PH_SIZE;
          end
        end
        PH_SIZE_NODIGIT: begin
          if (head_i.is_semi || head_i.is_cr) begin
            err_d = ERR_EMPTY; phase_d = PH_ERROR; kind = KIND_ERROR;
          end
        end
        PH_SIZE: begin
          priority if (head_i.is_semi) begin
            phase_d = PH_EXT;
          end else if (head_i.is_cr) begin
            phase_d = PH_SIZE_LF;
          end else if (!ended_q) begin
            priority if (!head_i.is_hex) begin
              ended_d = 1'b1;
            end else if (rem_q[SIZE_BITS-1 -: 4] != 4'h0) begin
              // another digit would not fit
              err_d = ERR_OVERFLOW; phase_d = PH_ERROR; kind = KIND_ERROR;
            end else begin
              rem_d = {rem_q[SIZE_BITS-5:0], head_i.hex_val};
            end
          end
        end
        PH_EXT: begin
          if (head_i.is_cr) begin
            phase_d = PH_SIZE_LF;
          end
        end
        PH_SIZE_LF: begin
          if (head_i.is_lf) begin
            phase_d = PH_DATA;
          end else begin
            err_d = ERR_SIZE_LF; phase_d = PH_ERROR; kind = KIND_ERROR;
          end
        end
        PH_DATA: begin
          kind  = KIND_DATA;
          data  = head_i.raw;
          rem_d = rem_dec;
          if (total_q != {COUNT_BITS{1'b1}}) begin
            total_d = total_q + 1'b1;
          end
          if (rem_dec == '0) begin
            cend    = 1'b1;
            phase_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (head_i.is_cr) begin
            phase_d = PH_DATA_LF;
          end else begin
            err_d = ERR_DATA_CRLF; phase_d = PH_ERROR; kind = KIND_ERROR;
          end
        end
        PH_DATA_LF: begin
          if (head_i.is_lf) begin
            phase_d = PH_SIZE_FIRST;
          end else begin
            err_d = ERR_DATA_CRLF; phase_d = PH_ERROR; kind = KIND_ERROR;
          end
        end
        PH_LAST_CR: begin
          if (head_i.is_cr) begin
            phase_d = PH_LAST_LF;
          end else begin
            err_d = ERR_LAST_CRLF; phase_d = PH_ERROR; kind = KIND_ERROR;
          end
        end
        PH_LAST_LF: begin
          if (head_i.is_lf) begin
            phase_d = PH_DONE;
            kind    = KIND_DONE;
          end else begin
            err_d = ERR_LAST_CRLF; phase_d = PH_ERROR; kind = KIND_ERROR;
          end
        end
        PH_DONE: begin
          kind = KIND_DONE;
        end
        default: begin
          phase_d = PH_ERROR;
          kind    = KIND_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE_FIRST;
      rem_q       <= '0;
      ended_q     <= 1'b0;
      total_q     <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        rem_q   <= rem_d;
        ended_q <= ended_d;
        total_q <= total_d;
        err_q   <= err_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_o.kind        <= kind;
      out_o.data_byte   <= data;
      out_o.chunk_end   <= cend;
      out_o.error_code  <= (kind == KIND_ERROR) ? err_d : ERR_NONE;
      out_o.total_bytes <= 32'(total_d[TOT_W-1:0]);
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

FILE: rtl/hcbd_checker.sv
// port checker for the chunked body decoder and its bind
`include "assert_macros.svh"

module hcbd_checker import hcbd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [7:0]  out_data_byte_i,
  input logic        out_chunk_end_i,
  input logic [2:0]  out_error_code_i
);

  // a stalled result beat stays valid and keeps its kind
  `HCBD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i))

  // error beats carry a known non-zero code, other beats none
  `HCBD_ASSERT_IMP(a_err_code, clk_i, rst_ni, out_valid_i && out_kind_i == KIND_ERROR, out_error_code_i != ERR_NONE && out_error_code_i <= ERR_LAST_CRLF)
  `HCBD_ASSERT_IMP(a_no_err, clk_i, rst_ni, out_valid_i && out_kind_i != KIND_ERROR, out_error_code_i == ERR_NONE)

  // payload fields are quiet unless the beat is payload
  `HCBD_ASSERT_IMP(a_data_quiet, clk_i, rst_ni, out_valid_i && out_kind_i != KIND_DATA, out_data_byte_i == 8'h00 && !out_chunk_end_i)

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_data_byte_i  (out_o.data_byte),
  .out_chunk_end_i  (out_o.chunk_end),
  .out_error_code_i (out_o.error_code)
);
